// File: rtl/key_matrix_column_decoder_top_defines.svh
// Assertion macros for the key matrix column decoder.
// Used by key_matrix_column_decoder_top; needs no other file.
`ifndef KEY_MATRIX_COLUMN_DECODER_TOP_DEFINES_SVH
`define KEY_MATRIX_COLUMN_DECODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every rising clock edge outside reset.
`define KMCD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Checked on every rising clock edge, reset included.
`define KMCD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define KMCD_ASSERT(label, prop, msg)
`define KMCD_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: rtl/kmcd_pkg.sv
// Package of the key matrix column decoder: key codes, the key map table,
// case and symbol translation functions and the translated key type. No dependencies.
package kmcd_pkg;

   typedef logic [7:0] code_type;

   localparam int NUM_COLUMNS_DEFAULT = 8;
   localparam int NUM_ROWS = 8;

   localparam code_type KC_ESC    = 8'h1b;
   localparam code_type KC_LSHIFT = 8'h0e;
   localparam code_type KC_RSHIFT = 8'h0f;
   localparam code_type KC_CAPS   = 8'hfe;
   localparam code_type KC_2ND    = 8'hfd;
   localparam code_type LOWER_A   = 8'h61;
   localparam code_type LOWER_Z   = 8'h7a;
   localparam code_type CASE_DIFF = 8'h20;

   // Indexed [shift][row][column].
   localparam code_type KEY_MAP [2][8][8] = '{
      '{
         '{8'h0e, 8'hf0, 8'hf1, 8'h20, 8'h1e, 8'h1f, 8'h1d, 8'h1c},
         '{8'h0f, 8'h2d, 8'h5b, 8'h61, 8'h73, 8'h74, 8'h72, 8'h34},
         '{8'hf2, 8'h3d, 8'h27, 8'h7a, 8'h64, 8'h79, 8'h65, 8'h35},
         '{8'h0d, 8'h5d, 8'h3b, 8'h78, 8'h66, 8'h75, 8'h77, 8'h36},
         '{8'h09, 8'h5c, 8'h2f, 8'h63, 8'h67, 8'h69, 8'h71, 8'h37},
         '{8'h1b, 8'h60, 8'h2e, 8'h76, 8'h68, 8'h6f, 8'h31, 8'h38},
         '{8'hfe, 8'h08, 8'h2c, 8'h62, 8'h6a, 8'h70, 8'h32, 8'h39},
         '{8'hfd, 8'hf3, 8'h6d, 8'h6e, 8'h6b, 8'h6c, 8'h33, 8'h30}
      },
      '{
         '{8'h0e, 8'hf0, 8'hf1, 8'h20, 8'h1e, 8'h1f, 8'h1d, 8'h1c},
         '{8'h0f, 8'h5f, 8'h7b, 8'h41, 8'h53, 8'h54, 8'h52, 8'h24},
         '{8'hf2, 8'h2b, 8'h22, 8'h5a, 8'h44, 8'h59, 8'h45, 8'h25},
         '{8'h0d, 8'h7d, 8'h3a, 8'h58, 8'h46, 8'h55, 8'h57, 8'h5e},
         '{8'h09, 8'h7c, 8'h3f, 8'h43, 8'h47, 8'h49, 8'h51, 8'h26},
         '{8'h1b, 8'h7e, 8'h3e, 8'h56, 8'h48, 8'h4f, 8'h21, 8'h2a},
         '{8'hfe, 8'h08, 8'h3c, 8'h42, 8'h4a, 8'h50, 8'h40, 8'h28},
         '{8'hfd, 8'hf3, 8'h4d, 8'h4e, 8'h4b, 8'h4c, 8'h23, 8'h29}
      }
   };

   // Result of looking up and classifying one key.
   typedef struct packed {
      logic     is_shift;
      logic     is_caps;
      logic     is_second;
      logic     is_char;
      code_type char_code;
   } key_type;

   function automatic code_type to_upper(input code_type c);
      code_type r;
      r = c;
      if (c >= LOWER_A && c <= LOWER_Z) begin
         r = c - CASE_DIFF;
      end
      return r;
   endfunction

   function automatic code_type to_symbol(input code_type c);
      code_type r;
      unique case (c)
         8'h27: r = 8'h22;
         8'h2c: r = 8'h3c;
         8'h2d: r = 8'h5f;
         8'h2e: r = 8'h3e;
         8'h2f: r = 8'h3f;
         8'h30: r = 8'h29;
         8'h31: r = 8'h21;
         8'h32: r = 8'h40;
         8'h33: r = 8'h23;
         8'h34: r = 8'h24;
         8'h35: r = 8'h25;
         8'h36: r = 8'h5e;
         8'h37: r = 8'h26;
         8'h38: r = 8'h2a;
         8'h39: r = 8'h28;
         8'h3b: r = 8'h3a;
         8'h3d: r = 8'h2b;
         8'h5b: r = 8'h7b;
         8'h5c: r = 8'h7c;
         8'h5d: r = 8'h7d;
         8'h60: r = 8'h7e;
         default: r = c;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/kmcd_xlate.sv
// Key translation unit: map lookup, Esc suppression, key classification and
// caps / second-function translation. Depends on kmcd_pkg.
module kmcd_xlate (
   input  logic             shift,
   input  logic [2:0]       row,
   input  logic [2:0]       col,
   input  logic             esc_enable,
   input  logic             caps_lock,
   input  logic             second_function,
   output kmcd_pkg::key_type key
);

   kmcd_pkg::code_type code_raw;
   kmcd_pkg::code_type code;
   kmcd_pkg::code_type cased;
   logic               special;

   always_comb begin
      code_raw = kmcd_pkg::KEY_MAP[shift][row][col];
      code = (!esc_enable && code_raw == kmcd_pkg::KC_ESC) ? 8'h00 : code_raw;

      key.is_shift  = (code == kmcd_pkg::KC_LSHIFT) || (code == kmcd_pkg::KC_RSHIFT);
      key.is_caps   = (code == kmcd_pkg::KC_CAPS);
      key.is_second = (code == kmcd_pkg::KC_2ND);
      special       = key.is_shift || key.is_caps || key.is_second;
      key.is_char   = (code != 8'h00) && !special;

      cased         = caps_lock ? kmcd_pkg::to_upper(code) : code;
      key.char_code = second_function ? kmcd_pkg::to_symbol(cased) : cased;
   end

endmodule

// File: rtl/key_matrix_column_decoder_top.sv
// Top level of the key matrix column decoder: debounce stores, row walk sequencer
// and output register. Depends on kmcd_pkg, kmcd_xlate and the defines header.
//
//   channel   direction  handshake                  payload
//   req       in         req_valid / req_stall      req_column, req_row_bits
//   rsp       out        rsp_valid / rsp_stall      rsp_char_code, rsp_last_of_run
//   csr       in         csr_write_enable           csr_write_data (esc_enable)
//
// A transaction is taken only while the sequencer is idle. The check state then compares the
// column against the debounce stores; a confirmed change walks the eight rows through the
// one translation unit, one row a cycle unless a new character waits on a stalled result,
// and the flush state then moves out the held character once the output is free. Reset sets
// all stored rows to released, caps lock on.
`include "key_matrix_column_decoder_top_defines.svh"

module key_matrix_column_decoder_top #(
   parameter int NUM_COLUMNS = kmcd_pkg::NUM_COLUMNS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_column,
   input  logic [7:0] req_row_bits,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_char_code,
   output logic       rsp_last_of_run,
   input  logic       csr_write_enable,
   input  logic       csr_write_data
);

   localparam int ColW = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CHECK = 2'd1;
   localparam logic [1:0] ST_WALK  = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [2:0] col_ff;
   logic [7:0] now_ff;
   logic [7:0] before_ff, before_in;
   logic [2:0] row_ff, row_in;

   logic [7:0] confirmed_ff [NUM_COLUMNS];
   logic [7:0] sampled_ff   [NUM_COLUMNS];

   logic esc_enable_ff;
   logic shift_ff, shift_in;
   logic caps_ff, caps_in;
   logic second_ff, second_in;

   logic               pend_valid_ff, pend_valid_in;
   kmcd_pkg::code_type pend_char_ff, pend_char_in;

   logic               out_valid_ff;
   kmcd_pkg::code_type out_char_ff;
   logic               out_last_ff;
   logic               out_free;
   logic               out_load;
   kmcd_pkg::code_type out_char_in;
   logic               out_last_in;

   logic              req_accept;
   logic              col_in_range;
   logic [ColW-1:0]   col_idx;
   logic              sample_write;
   logic              confirm_write;
   logic              row_diff;
   logic              was_up;
   logic              emit;
   logic              walk_adv;
   kmcd_pkg::key_type key;

   kmcd_xlate u_xlate (
      .shift           (shift_ff),
      .row             (row_ff),
      .col             (col_ff),
      .esc_enable      (esc_enable_ff),
      .caps_lock       (caps_ff),
      .second_function (second_ff),
      .key             (key)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   assign col_in_range = ({29'd0, col_ff} < NUM_COLUMNS);
   assign col_idx      = col_ff[ColW-1:0];

   assign row_diff = before_ff[row_ff] != now_ff[row_ff];
   assign was_up   = before_ff[row_ff];
   assign emit     = row_diff && was_up && key.is_char;
   assign out_free = !out_valid_ff || !rsp_stall;
   // A new character can be held only when the one already held can move out.
   assign walk_adv = !(emit && pend_valid_ff && !out_free);

   always_comb begin
      state_in      = state_ff;
      before_in     = before_ff;
      row_in        = row_ff;
      shift_in      = shift_ff;
      caps_in       = caps_ff;
      second_in     = second_ff;
      pend_valid_in = pend_valid_ff;
      pend_char_in  = pend_char_ff;
      out_load      = 1'b0;
      out_char_in   = pend_char_ff;
      out_last_in   = 1'b0;
      sample_write  = 1'b0;
      confirm_write = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = ST_IDLE;
            if (col_in_range) begin
               if (sampled_ff[col_idx] != now_ff) begin
                  sample_write = 1'b1;
               end else if (confirmed_ff[col_idx] != now_ff) begin
                  before_in = confirmed_ff[col_idx];
                  row_in    = 3'd0;
                  state_in  = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (walk_adv) begin
               if (emit) begin
                  if (pend_valid_ff) begin
                     out_load = 1'b1;
                  end
                  pend_valid_in = 1'b1;
                  pend_char_in  = key.char_code;
               end
               if (row_diff && was_up) begin
                  if (key.is_shift) begin
                     shift_in = 1'b1;
                  end else if (key.is_caps) begin
                     caps_in = !caps_ff;
                  end else if (key.is_second) begin
                     second_in = !second_ff;
                  end
               end else if (row_diff && key.is_shift) begin
                  shift_in = 1'b0;
               end
               row_in = row_ff + 3'd1;
               if (row_ff == 3'd7) begin
                  confirm_write = 1'b1;
                  state_in      = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_load      = 1'b1;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         esc_enable_ff <= 1'b1;
         shift_ff      <= 1'b0;
         caps_ff       <= 1'b1;
         second_ff     <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         for (int i = 0; i < NUM_COLUMNS; i++) begin
            confirmed_ff[i] <= 8'hff;
            sampled_ff[i]   <= 8'hff;
         end
      end else begin
         state_ff      <= state_in;
         shift_ff      <= shift_in;
         caps_ff       <= caps_in;
         second_ff     <= second_in;
         pend_valid_ff <= pend_valid_in;
         if (csr_write_enable) begin
            esc_enable_ff <= csr_write_data;
         end
         if (sample_write) begin
            sampled_ff[col_idx] <= now_ff;
         end
         if (confirm_write) begin
            confirmed_ff[col_idx] <= now_ff;
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         col_ff <= req_column;
         now_ff <= req_row_bits;
      end
      before_ff    <= before_in;
      row_ff       <= row_in;
      pend_char_ff <= pend_char_in;
      if (out_load) begin
         out_char_ff <= out_char_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_char_code   = out_char_ff;
   assign rsp_last_of_run = out_last_ff;

   `KMCD_ASSERT(a_accept_starts_check, req_accept |=> state_ff == ST_CHECK, "accept did not start check")
   `KMCD_ASSERT(a_pend_only_in_walk, pend_valid_ff |-> (state_ff == ST_WALK || state_ff == ST_FLUSH), "held character outside walk")
   `KMCD_ASSERT(a_walk_ends_in_flush, (state_ff == ST_WALK && walk_adv && row_ff == 3'd7) |=> state_ff == ST_FLUSH, "walk did not end in flush")
   `KMCD_ASSERT(a_flush_marks_last, (state_ff == ST_FLUSH && pend_valid_ff && out_free) |=> (rsp_valid && rsp_last_of_run && !pend_valid_ff), "flush did not deliver last character")
   `KMCD_ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == ST_IDLE && !rsp_valid), "reset did not idle the block")

endmodule
